FILE: rtl/awvn_pkg.sv
// Shared types, command codes, sequencer states and the CORDIC arctangent table
// for the angle-weighted vertex normal block. No dependencies.
package awvn_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int IDX_W        = 10;
	localparam int CORDIC_STEPS = 16;
	localparam int DIV_BITS     = 18;   // quotient bits of the scale divider
	localparam int SQRT_STEPS   = 32;   // result bits of the square root

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_FACE = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

	typedef logic signed [23:0] coord_t;
	typedef coord_t [2:0]       pos3_t;    // element 0 is x
	typedef logic signed [31:0] sum_el_t;
	typedef sum_el_t [2:0]      sum3_t;    // element 0 is x

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FPOS,
		ST_FDIFF,
		ST_FCROSS,
		ST_FMAG,
		ST_FSHR,
		ST_SQ,
		ST_SQRT,
		ST_CORDIC,
		ST_THETA,
		ST_SCALE,
		ST_DIV,
		ST_FUPD_RD,
		ST_FUPD_WR,
		ST_RGET,
		ST_RSHL,
		ST_OUT
	} state_t;

	// floor(atan(2^-i) * 2^30)
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0:    r = 30'd843314856;
			5'd1:    r = 30'd497837829;
			5'd2:    r = 30'd263043836;
			5'd3:    r = 30'd133525158;
			5'd4:    r = 30'd67021686;
			5'd5:    r = 30'd33543515;
			5'd6:    r = 30'd16775850;
			5'd7:    r = 30'd8388437;
			5'd8:    r = 30'd4194282;
			5'd9:    r = 30'd2097149;
			5'd10:   r = 30'd1048575;
			5'd11:   r = 30'd524287;
			5'd12:   r = 30'd262143;
			5'd13:   r = 30'd131071;
			5'd14:   r = 30'd65535;
			5'd15:   r = 30'd32767;
			5'd16:   r = 30'd16383;
			5'd17:   r = 30'd8191;
			5'd18:   r = 30'd4095;
			5'd19:   r = 30'd2047;
			5'd20:   r = 30'd1023;
			5'd21:   r = 30'd511;
			5'd22:   r = 30'd255;
			5'd23:   r = 30'd127;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/awvn_req_if.sv
// Request channel: command, vertex position and triangle corners.
// Depends on nothing.
interface awvn_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [9:0]  vertex_index;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic signed [23:0] pos_z;
	logic [9:0]  corner_a;
	logic [9:0]  corner_b;
	logic [9:0]  corner_c;

	modport source (output valid, cmd, vertex_index, pos_x, pos_y, pos_z,
		corner_a, corner_b, corner_c, input ready);
	modport sink (input valid, cmd, vertex_index, pos_x, pos_y, pos_z,
		corner_a, corner_b, corner_c, output ready);
endinterface

FILE: rtl/awvn_rsp_if.sv
// Response channel: normalized vertex normal and zero flag.
// Depends on nothing.
interface awvn_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic        zero_normal;

	modport source (output valid, normal_x, normal_y, normal_z, zero_normal, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, zero_normal, output ready);
endinterface

FILE: rtl/angle_weighted_vertex_normals.sv
// Angle-weighted vertex normal engine: position and normal-sum memories and a
// sequencer around one shared multiplier, root, divider and CORDIC datapath.
// Depends on awvn_pkg, awvn_req_if and awvn_rsp_if.
//
// A load item writes a Q8.16 position and clears that vertex's normal sum. A
// face item (a, b, c) forms n = (b-a) x (c-a), measures the angle at a with a
// 16-step CORDIC on (|ab.ac|, |n|) and adds unit(n) * angle, rounded in Q3.16,
// to the saturating sums of a, b and c. A read item returns the sum normalized
// to Q1.15, or zeros with zero_normal set for a zero sum. Only read produces a
// result. The block takes one item at a time: req.ready is high only while the
// sequencer idles. A degenerate face ends early and leaves the sums unchanged.
// The time is set mostly by the 32-step bit-serial square root and three
// 18-step restoring divides, all on the one shared datapath. A face's nine
// cross/dot products, three squares and three scale products, and a read's
// three squares, go through a single 33x33 multiplier. The magnitude
// alignment loops shift one bit per cycle, by up to 20 bits right for a face
// and up to 30 bits left for a read. A finished read waits in the output
// register, which frees as soon as rsp.ready takes it. The memories have no
// reset; reading a vertex never loaded is undefined.
module angle_weighted_vertex_normals (
	input  logic clk,
	input  logic arst_n,
	awvn_req_if.sink   req,
	awvn_rsp_if.source rsp
);

	awvn_pkg::state_t state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       ph_q, ph_d;
	logic [1:0] comp_q, comp_d;
	logic [1:0] tgt_q, tgt_d;
	logic       ov_q;

	// memories
	awvn_pkg::pos3_t pos_mem [awvn_pkg::MAX_VERTICES];
	awvn_pkg::sum3_t sum_mem [awvn_pkg::MAX_VERTICES];
	awvn_pkg::pos3_t pos_rd_q;
	awvn_pkg::sum3_t sum_rd_q;
	logic [9:0] pos_raddr, sum_raddr, tgt_addr;

	// corners and positions
	logic [9:0] a_q, b_q, c_q;
	awvn_pkg::pos3_t p_q [3];
	logic signed [24:0] ab_q [3];
	logic signed [24:0] ac_q [3];
	logic signed [51:0] vec_q [4];

	// magnitudes
	logic [51:0] mag_q [3];
	logic        neg_q [3];
	logic [51:0] dm_q;
	logic        big;

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] ma_w, mb_w;
	logic signed [65:0] prod_q;
	logic [1:0]  x_dst;
	logic        x_sub;

	// sum of squares and root
	logic [63:0] acc_q, acc_nx;
	logic [63:0] sr_v_q, sr_r_q, sr_bit_q;
	logic [63:0] sr_trial, sr_v_nx, sr_r_nx;
	logic        sr_ge;
	logic [31:0] len_q;

	// CORDIC
	logic signed [35:0] cx_q, cy_q, cx_nx, cy_nx, cdx, cdy;
	logic signed [33:0] cz_q, cz_nx, catan, zc;
	logic [33:0] tsum;
	logic [16:0] theta_q;

	// divider
	logic [49:0] num;
	logic [31:0] rem_q, rem_nx;
	logic [17:0] lo_q, quo_q, quo_nx;
	logic [32:0] dv_t;
	logic        dv_ge;
	logic [32:0] dv_diff;

	// results
	logic signed [18:0] contrib_q [3];
	logic signed [15:0] nrm_q [3];
	logic        zflag_q;
	logic signed [15:0] nx_q, ny_q, nz_q;
	logic        zo_q;
	awvn_pkg::sum3_t sat_sum;

	logic req_fire, out_fire, last_sq, sq_zero;

	assign req_fire = req.valid && req.ready;
	assign out_fire = (state_q == awvn_pkg::ST_OUT) && (!ov_q || rsp.ready);

	assign req.ready       = (state_q == awvn_pkg::ST_IDLE);
	assign rsp.valid       = ov_q;
	assign rsp.normal_x    = nx_q;
	assign rsp.normal_y    = ny_q;
	assign rsp.normal_z    = nz_q;
	assign rsp.zero_normal = zo_q;

	// command of the item in flight
	logic [1:0] cmd_q;
	logic       face_mode;
	assign face_mode = (cmd_q == awvn_pkg::CMD_FACE);

	// ---------------- address selection ----------------
	always_comb begin
		case (tgt_q)
			2'd0:    tgt_addr = a_q;
			2'd1:    tgt_addr = b_q;
			default: tgt_addr = c_q;
		endcase
		case (cnt_q)
			5'd0:    pos_raddr = a_q;
			5'd1:    pos_raddr = b_q;
			default: pos_raddr = c_q;
		endcase
		sum_raddr = (state_q == awvn_pkg::ST_IDLE) ? req.vertex_index : tgt_addr;
	end

	// alignment limit: any magnitude at or above 2^30
	always_comb begin
		big = (|dm_q[51:30]);
		for (int k = 0; k < 3; k++) begin
			big = big | (|mag_q[k][51:30]);
		end
	end

	// ---------------- shared multiplier operands ----------------
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		x_dst = 2'd3;
		x_sub = 1'b0;
		case (state_q)
			awvn_pkg::ST_FCROSS: begin
				case (cnt_q)
					5'd0: begin mul_a = 33'(ab_q[1]); mul_b = 33'(ac_q[2]); x_dst = 2'd0; end
					5'd1: begin
						mul_a = 33'(ab_q[2]); mul_b = 33'(ac_q[1]); x_dst = 2'd0; x_sub = 1'b1;
					end
					5'd2: begin mul_a = 33'(ab_q[2]); mul_b = 33'(ac_q[0]); x_dst = 2'd1; end
					5'd3: begin
						mul_a = 33'(ab_q[0]); mul_b = 33'(ac_q[2]); x_dst = 2'd1; x_sub = 1'b1;
					end
					5'd4: begin mul_a = 33'(ab_q[0]); mul_b = 33'(ac_q[1]); x_dst = 2'd2; end
					5'd5: begin
						mul_a = 33'(ab_q[1]); mul_b = 33'(ac_q[0]); x_dst = 2'd2; x_sub = 1'b1;
					end
					5'd6: begin mul_a = 33'(ab_q[0]); mul_b = 33'(ac_q[0]); end
					5'd7: begin mul_a = 33'(ab_q[1]); mul_b = 33'(ac_q[1]); end
					default: begin mul_a = 33'(ab_q[2]); mul_b = 33'(ac_q[2]); end
				endcase
			end
			awvn_pkg::ST_SQ: begin
				mul_a = $signed({1'b0, mag_q[cnt_q[1:0]][31:0]});
				mul_b = mul_a;
			end
			awvn_pkg::ST_SCALE: begin
				mul_a = $signed({1'b0, mag_q[comp_q][31:0]});
				mul_b = $signed({16'd0, theta_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign ma_w = 66'(mul_a);
	assign mb_w = 66'(mul_b);
	assign acc_nx  = acc_q + prod_q[63:0];
	assign last_sq = (state_q == awvn_pkg::ST_SQ) && ph_q && (cnt_q == 5'd2);
	assign sq_zero = (acc_nx == 64'd0);

	// ---------------- square root step ----------------
	always_comb begin
		sr_trial = sr_r_q + sr_bit_q;
		sr_ge    = (sr_v_q >= sr_trial);
		sr_v_nx  = sr_ge ? (sr_v_q - sr_trial) : sr_v_q;
		sr_r_nx  = sr_ge ? ((sr_r_q >> 1) + sr_bit_q) : (sr_r_q >> 1);
	end

	// ---------------- CORDIC step, rotate toward y = 0 ----------------
	always_comb begin
		cdx   = cy_q >>> cnt_q;
		cdy   = cx_q >>> cnt_q;
		catan = $signed({4'd0, awvn_pkg::atan_q30(cnt_q)});
		if (!cy_q[35] && (cy_q != '0)) begin
			cx_nx = cx_q + cdx;
			cy_nx = cy_q - cdy;
			cz_nx = cz_q + catan;
		end else begin
			cx_nx = cx_q - cdx;
			cy_nx = cy_q + cdy;
			cz_nx = cz_q - catan;
		end
		if (cz_q[33]) begin
			zc = '0;
		end else if (cz_q > awvn_pkg::HALF_PI_Q30) begin
			zc = awvn_pkg::HALF_PI_Q30;
		end else begin
			zc = cz_q;
		end
		tsum = 34'(zc) + 34'd8192;
	end

	// ---------------- divider step and numerator ----------------
	always_comb begin
		dv_t    = {rem_q, lo_q[17]};
		dv_ge   = (dv_t >= {1'b0, len_q});
		dv_diff = dv_t - {1'b0, len_q};
		rem_nx  = dv_ge ? dv_diff[31:0] : dv_t[31:0];
		quo_nx  = {quo_q[16:0], dv_ge};
		if (face_mode) begin
			num = prod_q[49:0] + 50'(len_q >> 1);
		end else begin
			num = {3'd0, mag_q[comp_q][31:0], 15'd0} + 50'(len_q >> 1);
		end
	end

	// saturating add of the face contribution to the sum being updated
	always_comb begin
		logic signed [33:0] s;
		for (int k = 0; k < 3; k++) begin
			s = 34'(sum_rd_q[k]) + 34'(contrib_q[k]);
			if (s[33] != s[31] || s[33] != s[32]) begin
				sat_sum[k] = s[33] ? 32'sh80000000 : 32'sh7FFFFFFF;
			end else begin
				sat_sum[k] = s[31:0];
			end
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= awvn_pkg::ST_IDLE;
			cnt_q   <= '0;
			ph_q    <= 1'b0;
			comp_q  <= '0;
			tgt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ph_q    <= ph_d;
			comp_q  <= comp_d;
			tgt_q   <= tgt_d;
			if (out_fire) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ph_d    = ph_q;
		comp_d  = comp_q;
		tgt_d   = tgt_q;
		unique case (state_q)
			awvn_pkg::ST_IDLE: begin
				cnt_d  = '0;
				ph_d   = 1'b0;
				comp_d = '0;
				tgt_d  = '0;
				if (req_fire) begin
					if (req.cmd == awvn_pkg::CMD_FACE) begin
						state_d = awvn_pkg::ST_FPOS;
					end else if (req.cmd == awvn_pkg::CMD_READ) begin
						state_d = awvn_pkg::ST_RGET;
					end
				end
			end
			awvn_pkg::ST_FPOS: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'd3) begin
					cnt_d   = '0;
					state_d = awvn_pkg::ST_FDIFF;
				end
			end
			awvn_pkg::ST_FDIFF: begin
				state_d = awvn_pkg::ST_FCROSS;
			end
			awvn_pkg::ST_FCROSS: begin
				ph_d = !ph_q;
				if (ph_q) begin
					cnt_d = cnt_q + 5'd1;
					if (cnt_q == 5'd8) begin
						cnt_d   = '0;
						state_d = awvn_pkg::ST_FMAG;
					end
				end
			end
			awvn_pkg::ST_FMAG: begin
				state_d = awvn_pkg::ST_FSHR;
			end
			awvn_pkg::ST_FSHR: begin
				if (!big) begin
					state_d = awvn_pkg::ST_SQ;
				end
			end
			awvn_pkg::ST_SQ: begin
				ph_d = !ph_q;
				if (ph_q) begin
					cnt_d = cnt_q + 5'd1;
					if (cnt_q == 5'd2) begin
						cnt_d   = '0;
						state_d = (face_mode && sq_zero) ? awvn_pkg::ST_IDLE
							: awvn_pkg::ST_SQRT;
					end
				end
			end
			awvn_pkg::ST_SQRT: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'(awvn_pkg::SQRT_STEPS - 1)) begin
					cnt_d   = '0;
					comp_d  = '0;
					state_d = face_mode ? awvn_pkg::ST_CORDIC : awvn_pkg::ST_SCALE;
				end
			end
			awvn_pkg::ST_CORDIC: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'(awvn_pkg::CORDIC_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = awvn_pkg::ST_THETA;
				end
			end
			awvn_pkg::ST_THETA: begin
				comp_d  = '0;
				ph_d    = 1'b0;
				state_d = awvn_pkg::ST_SCALE;
			end
			awvn_pkg::ST_SCALE: begin
				cnt_d = '0;
				if (face_mode && !ph_q) begin
					ph_d = 1'b1;
				end else begin
					ph_d    = 1'b0;
					state_d = awvn_pkg::ST_DIV;
				end
			end
			awvn_pkg::ST_DIV: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'(awvn_pkg::DIV_BITS - 1)) begin
					cnt_d = '0;
					tgt_d = '0;
					if (comp_q == 2'd2) begin
						state_d = face_mode ? awvn_pkg::ST_FUPD_RD : awvn_pkg::ST_OUT;
					end else begin
						comp_d  = comp_q + 2'd1;
						state_d = awvn_pkg::ST_SCALE;
					end
				end
			end
			awvn_pkg::ST_FUPD_RD: begin
				state_d = awvn_pkg::ST_FUPD_WR;
			end
			awvn_pkg::ST_FUPD_WR: begin
				tgt_d   = tgt_q + 2'd1;
				state_d = (tgt_q == 2'd2) ? awvn_pkg::ST_IDLE : awvn_pkg::ST_FUPD_RD;
			end
			awvn_pkg::ST_RGET: begin
				cnt_d = '0;
				ph_d  = 1'b0;
				if ((sum_rd_q[0] == '0) && (sum_rd_q[1] == '0) && (sum_rd_q[2] == '0)) begin
					state_d = awvn_pkg::ST_OUT;
				end else begin
					state_d = awvn_pkg::ST_RSHL;
				end
			end
			awvn_pkg::ST_RSHL: begin
				if (big) begin
					state_d = awvn_pkg::ST_SQ;
				end
			end
			awvn_pkg::ST_OUT: begin
				if (!ov_q || rsp.ready) begin
					state_d = awvn_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = awvn_pkg::ST_IDLE;
			end
		endcase
	end

	// ---------------- memories ----------------
	always_ff @(posedge clk) begin
		pos_rd_q <= pos_mem[pos_raddr];
		sum_rd_q <= sum_mem[sum_raddr];
		if (req_fire && (req.cmd == awvn_pkg::CMD_LOAD)) begin
			pos_mem[req.vertex_index] <= {req.pos_z, req.pos_y, req.pos_x};
			sum_mem[req.vertex_index] <= '0;
		end else if (state_q == awvn_pkg::ST_FUPD_WR) begin
			sum_mem[tgt_addr] <= sat_sum;
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		prod_q <= ma_w * mb_w;
		case (state_q)
			awvn_pkg::ST_IDLE: begin
				cmd_q <= req.cmd;
				a_q   <= req.corner_a;
				b_q   <= req.corner_b;
				c_q   <= req.corner_c;
			end
			awvn_pkg::ST_FPOS: begin
				if (cnt_q != 5'd0) begin
					p_q[cnt_q[1:0] - 2'd1] <= pos_rd_q;
				end
			end
			awvn_pkg::ST_FDIFF: begin
				for (int k = 0; k < 3; k++) begin
					ab_q[k]  <= 25'(p_q[1][k]) - 25'(p_q[0][k]);
					ac_q[k]  <= 25'(p_q[2][k]) - 25'(p_q[0][k]);
				end
				for (int k = 0; k < 4; k++) begin
					vec_q[k] <= '0;
				end
			end
			awvn_pkg::ST_FCROSS: begin
				if (ph_q) begin
					if (x_sub) begin
						vec_q[x_dst] <= vec_q[x_dst] - prod_q[51:0];
					end else begin
						vec_q[x_dst] <= vec_q[x_dst] + prod_q[51:0];
					end
				end
			end
			awvn_pkg::ST_FMAG: begin
				for (int k = 0; k < 3; k++) begin
					mag_q[k] <= vec_q[k][51] ? 52'(-vec_q[k]) : 52'(vec_q[k]);
					neg_q[k] <= vec_q[k][51];
				end
				dm_q <= vec_q[3][51] ? 52'(-vec_q[3]) : 52'(vec_q[3]);
			end
			awvn_pkg::ST_FSHR: begin
				if (big) begin
					for (int k = 0; k < 3; k++) begin
						mag_q[k] <= mag_q[k] >> 1;
					end
					dm_q <= dm_q >> 1;
				end else begin
					acc_q <= '0;
				end
			end
			awvn_pkg::ST_SQ: begin
				if (ph_q) begin
					acc_q <= acc_nx;
				end
				if (last_sq) begin
					sr_v_q   <= acc_nx;
					sr_r_q   <= '0;
					sr_bit_q <= 64'd1 << 62;
				end
			end
			awvn_pkg::ST_SQRT: begin
				sr_v_q   <= sr_v_nx;
				sr_r_q   <= sr_r_nx;
				sr_bit_q <= sr_bit_q >> 2;
				if (cnt_q == 5'(awvn_pkg::SQRT_STEPS - 1)) begin
					len_q <= sr_r_nx[31:0];
					cx_q  <= $signed({4'd0, dm_q[31:0]});
					cy_q  <= $signed({4'd0, sr_r_nx[31:0]});
					cz_q  <= '0;
				end
			end
			awvn_pkg::ST_CORDIC: begin
				cx_q <= cx_nx;
				cy_q <= cy_nx;
				cz_q <= cz_nx;
			end
			awvn_pkg::ST_THETA: begin
				theta_q <= tsum[30:14];
			end
			awvn_pkg::ST_SCALE: begin
				if (!face_mode || ph_q) begin
					rem_q <= num[49:18];
					lo_q  <= num[17:0];
					quo_q <= '0;
				end
			end
			awvn_pkg::ST_DIV: begin
				rem_q <= rem_nx;
				lo_q  <= {lo_q[16:0], 1'b0};
				quo_q <= quo_nx;
				if (cnt_q == 5'(awvn_pkg::DIV_BITS - 1)) begin
					if (face_mode) begin
						contrib_q[comp_q] <= neg_q[comp_q] ? -$signed({1'b0, quo_nx})
							: $signed({1'b0, quo_nx});
					end else if (neg_q[comp_q]) begin
						nrm_q[comp_q] <= 16'(-$signed({1'b0, quo_nx[16:0]}));
					end else if (quo_nx[16:15] != 2'd0) begin
						nrm_q[comp_q] <= 16'sh7FFF;
					end else begin
						nrm_q[comp_q] <= $signed(quo_nx[15:0]);
					end
				end
			end
			awvn_pkg::ST_RGET: begin
				for (int k = 0; k < 3; k++) begin
					mag_q[k] <= sum_rd_q[k][31] ? {20'd0, 32'(-sum_rd_q[k])}
						: {20'd0, sum_rd_q[k]};
					neg_q[k] <= sum_rd_q[k][31];
					nrm_q[k] <= '0;
				end
				dm_q    <= '0;
				acc_q   <= '0;
				zflag_q <= (sum_rd_q[0] == '0) && (sum_rd_q[1] == '0) && (sum_rd_q[2] == '0);
			end
			awvn_pkg::ST_RSHL: begin
				if (!big) begin
					for (int k = 0; k < 3; k++) begin
						mag_q[k] <= mag_q[k] << 1;
					end
				end
			end
			awvn_pkg::ST_OUT: begin
				if (out_fire) begin
					nx_q <= nrm_q[0];
					ny_q <= nrm_q[1];
					nz_q <= nrm_q[2];
					zo_q <= zflag_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
